// ----- design/log_record_checker_crc32_macros.svh -----
// Assertion macros for the log record checker.
`ifndef LOG_RECORD_CHECKER_CRC32_MACROS_SVH
`define LOG_RECORD_CHECKER_CRC32_MACROS_SVH
`ifndef ASSERT_OFF
`define LRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LRC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRC_ASSERT(label, clk, rst_n, prop, msg)
`define LRC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- design/lrc_pkg.sv -----
// Shared types, codes and CRC function for the log record checker.
`default_nettype none
package lrc_pkg;
  typedef enum logic [2:0] {
    PH_HEADER, PH_TIME, PH_VALUE, PH_LENGTH, PH_NAME, PH_CRC, PH_STOP
  } phase_t;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_CLEAN_END = 4'd1;
  localparam logic [3:0] ST_SHORT_HDR = 4'd2;
  localparam logic [3:0] ST_BAD_MAGIC = 4'd3;
  localparam logic [3:0] ST_BAD_VER   = 4'd4;
  localparam logic [3:0] ST_TRUNC     = 4'd5;
  localparam logic [3:0] ST_NONFINITE = 4'd6;
  localparam logic [3:0] ST_BAD_LEN   = 4'd7;
  localparam logic [3:0] ST_NONPRINT  = 4'd8;
  localparam logic [3:0] ST_NO_CRC    = 4'd9;
  localparam logic [3:0] ST_CRC_BAD   = 4'd10;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [8:0]  NAME_MAX = 9'd256;
  localparam logic [7:0]  PRINT_LOW = 8'd32;
  localparam logic [7:0]  PRINT_HIGH = 8'd126;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  nbyte;
    logic [63:0] rtime;
    logic [63:0] vbits;
    logic [8:0]  nlen;
    logic [3:0]  status;
    logic [1:0]  ver;
  } result_t;

  // one step's work: up to two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } work_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- design/log_record_checker_crc32.sv -----
// Top level of the log record checker with CRC-32.
// Channel | Direction | Ports
// in_     | input     | in_valid, in_stall, in_start_of_log, in_end_of_log, in_data_byte
// out_    | output    | out_valid, out_stall, out_result_kind .. out_log_version
// cfg_    | input     | cfg_wr_en, cfg_wr_data (expected_magic)
// One byte per cycle is parsed while in_stall is low; the front CRC and field checks finish in that cycle.
// A byte giving two results occupies the output for two transfers.
// A 4-entry queue between parser and output lets input continue while output stalls.
// in_stall rises only when the queue is full. Synchronous active-low reset.
`default_nettype none
module log_record_checker_crc32 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_start_of_log,
  input  wire logic        in_end_of_log,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_name_byte,
  output logic signed [63:0] out_record_time,
  output logic [63:0]      out_value_bits,
  output logic [8:0]       out_name_length,
  output logic [3:0]       out_status,
  output logic [1:0]       out_log_version
);
  import lrc_pkg::*;

  work_t   work;
  logic    work_valid, space, step;
  result_t res;

  assign in_stall = !space;
  assign step = in_valid && space;

  lrc_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .step,
    .start_of_log(in_start_of_log), .end_of_log(in_end_of_log),
    .data_byte(in_data_byte), .work, .work_valid
  );

  lrc_back u_back (
    .clk, .rst_n, .push(step && work_valid), .work, .space,
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_result_kind = res.kind;
  assign out_name_byte   = res.nbyte;
  assign out_record_time = res.rtime;
  assign out_value_bits  = res.vbits;
  assign out_name_length = res.nlen;
  assign out_status      = res.status;
  assign out_log_version = res.ver;
endmodule
`default_nettype wire

// ----- design/lrc_front.sv -----
// Front end: parses bytes and classifies them into result groups.
`default_nettype none
module lrc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [15:0]     cfg_wr_data,
  input  wire logic            step,
  input  wire logic            start_of_log,
  input  wire logic            end_of_log,
  input  wire logic [7:0]      data_byte,
  output lrc_pkg::work_t       work,
  output logic                 work_valid
);
  import lrc_pkg::*;

  logic [15:0] magic_r;
  phase_t phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [63:0] time_r, time_nxt, val_r, val_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] crc_r, crc_nxt, scrc_r, scrc_nxt;
  logic        bad_r, bad_nxt;
  logic [1:0]  ver_r, ver_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) magic_r <= '0;
    else if (cfg_wr_en) magic_r <= cfg_wr_data;
  end

  always_comb begin
    phase_t ph;
    logic [8:0]  p, pos1;
    logic [31:0] h, sc;
    logic [63:0] t, v;
    logic [15:0] l;
    logic [31:0] c;
    logic        bd;
    logic [1:0]  vr;
    result_t     rv;
    ph = phase_r; p = pos_r; h = hdr_r; t = time_r; v = val_r; l = len_r;
    c = crc_r; sc = scrc_r; bd = bad_r; vr = ver_r;
    if (start_of_log) begin
      ph = PH_HEADER; h = '0; vr = '0; p = '0; t = '0; v = '0; l = '0;
      c = CRC_INIT; sc = '0; bd = 1'b0;
    end
    work_valid = 1'b0;
    work = '0;
    pos1 = p + 9'd1;
    rv = '{kind: KIND_VERDICT, nbyte: 8'd0, rtime: t, vbits: v, nlen: 9'd0,
           status: ST_OK, ver: vr};
    if (ph == PH_STOP) begin
    end else if (end_of_log) begin
      work_valid = 1'b1;
      unique case (ph)
        PH_HEADER: rv.status = ST_SHORT_HDR;
        PH_TIME:   rv.status = (p == 9'd0) ? ST_CLEAN_END : ST_TRUNC;
        PH_NAME:   begin rv.status = ST_TRUNC; rv.nlen = l[8:0]; end
        PH_CRC:    begin rv.status = ST_NO_CRC; rv.nlen = l[8:0]; end
        default:   rv.status = ST_TRUNC;
      endcase
      work.r0 = rv;
      ph = PH_STOP;
    end else begin
      unique case (ph)
        PH_HEADER: begin
          h[8*p[1:0] +: 8] = data_byte;
          p = pos1;
          if (p >= 9'd4) begin
            work_valid = 1'b1;
            if (h[15:0] != magic_r) begin
              rv.status = ST_BAD_MAGIC; work.r0 = rv; ph = PH_STOP;
            end else if (h[31:16] != 16'd1 && h[31:16] != 16'd2) begin
              rv.status = ST_BAD_VER; work.r0 = rv; ph = PH_STOP;
            end else begin
              vr = h[17:16];
              ph = PH_TIME; p = '0; t = '0; v = '0; l = '0;
              c = CRC_INIT; sc = '0; bd = 1'b0;
              work.r0 = '{kind: KIND_HEADER, nbyte: 8'd0, rtime: 64'd0,
                          vbits: 64'd0, nlen: 9'd0, status: ST_OK, ver: vr};
            end
          end
        end
        PH_TIME: begin
          c = crc_byte(c, data_byte);
          t[8*p[2:0] +: 8] = data_byte;
          p = pos1;
          if (p >= 9'd8) begin ph = PH_VALUE; p = '0; end
        end
        PH_VALUE: begin
          c = crc_byte(c, data_byte);
          v[8*p[2:0] +: 8] = data_byte;
          p = pos1;
          if (p >= 9'd8) begin
            p = '0;
            if (v[62:52] == 11'h7FF) begin
              rv.vbits = v; rv.status = ST_NONFINITE;
              work.r0 = rv; work_valid = 1'b1; ph = PH_STOP;
            end else ph = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          c = crc_byte(c, data_byte);
          l[8*p[0] +: 8] = data_byte;
          p = pos1;
          if (p >= 9'd2) begin
            p = '0;
            if (l == 16'd0 || l > {7'd0, NAME_MAX}) begin
              rv.status = ST_BAD_LEN; work.r0 = rv; work_valid = 1'b1; ph = PH_STOP;
            end else ph = PH_NAME;
          end
        end
        PH_NAME: begin
          c = crc_byte(c, data_byte);
          if (data_byte < PRINT_LOW || data_byte > PRINT_HIGH) bd = 1'b1;
          work_valid = 1'b1;
          work.r0 = '{kind: KIND_NAME, nbyte: data_byte, rtime: 64'd0,
                      vbits: 64'd0, nlen: 9'd0, status: ST_OK, ver: vr};
          p = pos1;
          if ({7'd0, p} >= l) begin
            p = '0;
            rv.nlen = l[8:0];
            if (bd) begin
              rv.status = ST_NONPRINT; work.two = 1'b1; work.r1 = rv; ph = PH_STOP;
            end else if (vr >= 2'd2) begin
              ph = PH_CRC;
            end else begin
              work.two = 1'b1; work.r1 = rv;
              ph = PH_TIME; t = '0; v = '0; l = '0; c = CRC_INIT; sc = '0; bd = 1'b0;
            end
          end
        end
        PH_CRC: begin
          sc[8*p[1:0] +: 8] = data_byte;
          p = pos1;
          if (p >= 9'd4) begin
            work_valid = 1'b1;
            rv.nlen = l[8:0];
            if (~c != sc) begin
              rv.status = ST_CRC_BAD; ph = PH_STOP;
            end else begin
              ph = PH_TIME; p = '0; t = '0; v = '0; l = '0;
              c = CRC_INIT; sc = '0; bd = 1'b0;
            end
            work.r0 = rv;
          end
        end
        default: ph = PH_STOP;
      endcase
    end
    phase_nxt = ph; pos_nxt = p; hdr_nxt = h; time_nxt = t; val_nxt = v;
    len_nxt = l; crc_nxt = c; scrc_nxt = sc; bad_nxt = bd; ver_nxt = vr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; pos_r <= '0; hdr_r <= '0; time_r <= '0; val_r <= '0;
      len_r <= '0; crc_r <= CRC_INIT; scrc_r <= '0; bad_r <= 1'b0; ver_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; hdr_r <= hdr_nxt; time_r <= time_nxt;
      val_r <= val_nxt; len_r <= len_nxt; crc_r <= crc_nxt; scrc_r <= scrc_nxt;
      bad_r <= bad_nxt; ver_r <= ver_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/lrc_back.sv -----
// Back end: result queue that emits one result per transfer.
`default_nettype none
`include "log_record_checker_crc32_macros.svh"
module lrc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lrc_pkg::work_t  work,
  output logic                 space,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lrc_pkg::result_t     out_res
);
  import lrc_pkg::*;

  work_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           half_r;
  logic           pop_entry, take;

  assign out_valid = (cnt_r != '0);
  assign take = out_valid && !out_stall;
  assign pop_entry = take && (!mem[rp_r].two || half_r);
  assign out_res = half_r ? mem[rp_r].r1 : mem[rp_r].r0;
  // space: a free entry this cycle
  assign space = (cnt_r != QDEPTH[QAW:0]);
  assign cnt_nxt = cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop_entry};

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= work;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; half_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop_entry) begin rp_r <= rp_r + QAW'(1); half_r <= 1'b0; end
      else if (take) half_r <= 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  `LRC_ASSERT(a_no_overflow, clk, rst_n, push |-> space, "queue overflow")
  `LRC_ASSERT(a_half_two, clk, rst_n, half_r |-> (out_valid && mem[rp_r].two), "bad half")
  `LRC_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= QDEPTH[QAW:0], "count out of range")
endmodule
`default_nettype wire
